### rtl/toy_vm_execute_unit_macros.svh
// Assertion macros for the toy VM execute unit.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef TOY_VM_EXECUTE_UNIT_MACROS_SVH
`define TOY_VM_EXECUTE_UNIT_MACROS_SVH

// Same-cycle implication.
`define TVM_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define TVM_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/tvm_pkg.sv
// Package for the toy VM execute unit: sizes, codes and payload types.
// No dependencies.
`timescale 1ns / 1ps

package tvm_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int NUM_REGS  = 8;
    localparam int WORDS     = MEM_BYTES / 2;
    localparam int MEM_AW    = $clog2(WORDS);
    localparam int REG_AW    = $clog2(NUM_REGS);

    localparam logic [REG_AW-1:0] SP_INDEX    = REG_AW'(7);
    localparam logic [16:0]       MEM_BYTES_W = 17'(MEM_BYTES);
    localparam logic [MEM_AW-1:0] CLR_LAST    = MEM_AW'(WORDS - 1);
    localparam logic [15:0]       POP_SP_MAX  = 16'hFFFD;
    localparam logic [15:0]       RET_SP_BAD  = 16'hFFFE;

    typedef enum logic [4:0] {
        OP_MOVRR  = 5'd0,
        OP_MOVRRP = 5'd1,
        OP_MOVRPR = 5'd2,
        OP_MOVRSI = 5'd3,
        OP_PUSH   = 5'd4,
        OP_POP    = 5'd5,
        OP_CALL   = 5'd6,
        OP_RET    = 5'd7,
        OP_ADD    = 5'd8,
        OP_SUB    = 5'd9,
        OP_MUL    = 5'd10,
        OP_DIV    = 5'd11,
        OP_AND    = 5'd12,
        OP_OR     = 5'd13,
        OP_XOR    = 5'd14,
        OP_NOT    = 5'd15,
        OP_SHL    = 5'd16,
        OP_SHR    = 5'd17,
        OP_HALT   = 5'd18,
        OP_NOP    = 5'd19,
        OP_JMP    = 5'd20,
        OP_JE     = 5'd21,
        OP_JNE    = 5'd22,
        OP_IN     = 5'd23,
        OP_OUT    = 5'd24
    } op_t;

    typedef enum logic [2:0] {
        STAT_CONT = 3'd0,
        STAT_HALT = 3'd1,
        STAT_OVF  = 3'd2,
        STAT_UMEM = 3'd3,
        STAT_USTK = 3'd4,
        STAT_DBZ  = 3'd5,
        STAT_IO   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_MEM,
        ST_WB2,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [4:0]  op;
        logic [15:0] instr;
        logic [15:0] next_ip;
        logic [7:0]  in_byte;
        logic        output_refused;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] new_ip;
        logic        out_valid;
        logic [7:0]  out_byte;
    } out_t;

    // Decisions of the execute stage.
    typedef struct packed {
        logic [2:0]        status;
        logic [15:0]       new_ip;
        logic              out_valid;
        logic [7:0]        out_byte;
        logic              rf_we;
        logic [REG_AW-1:0] rf_waddr;
        logic [15:0]       rf_wdata;
        logic              mem_we;
        logic              mem_re;
        logic [15:0]       mem_addr;
        logic [15:0]       mem_wdata;
        logic              div_start;
    } exec_t;

endpackage

### rtl/toy_vm_execute_unit.sv
// Top level of the toy VM execute unit: sequencer, register file and word memory.
// Depends on tvm_pkg, tvm_ram, tvm_exec, tvm_div and the assertion macros header.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_ready  | in_t  (op, instr, next_ip, in_byte, output_refused)
//  rsp     | out | rsp_valid/rsp_ready  | out_t (status, new_ip, out_valid, out_byte)
//
// One instruction at a time: accept, register-file read, execute. Most ops finish in the
// execute state; memory reads (movRRp, ret) pass through ST_MEM, pop through ST_MEM and
// then ST_WB2. Divide runs its bit-serial loop in ST_DIV until the divider is done.
// After reset a clearing pass zeroes all WORDS (32768) words of the word memory; no
// transaction is accepted meanwhile. A held result does not stop the next acceptance.
`timescale 1ns / 1ps
`include "toy_vm_execute_unit_macros.svh"

module toy_vm_execute_unit import tvm_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  in_t  req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output out_t rsp
);

    state_t            state_reg, state_next;
    in_t               cur_reg;
    logic [REG_AW-1:0] addr_a_reg, addr_a;
    logic [15:0]       a_reg;
    logic [NUM_REGS-1:0] rf_valid_reg;
    logic [MEM_AW-1:0] clr_cnt_reg;
    out_t              res_reg, res_next, out_reg;
    logic              out_full_reg, out_load, finish;

    logic              accept;
    logic [15:0]       rdata_a, rdata_b, opa, opb;
    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [15:0]       rf_wdata;
    logic              mem_we, mem_re;
    logic [MEM_AW-1:0] mem_addr;
    logic [15:0]       mem_wdata, mem_rdata;
    logic              div_start, div_done;
    logic [15:0]       quotient;
    exec_t             ex;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    // Register-file port A address depends on the operation's operand layout.
    always_comb
    begin
        unique case (req.op)
            OP_PUSH, OP_POP, OP_CALL, OP_RET: addr_a = SP_INDEX;
            OP_JMP, OP_JE, OP_JNE:            addr_a = req.instr[10:8];
            OP_SHL, OP_SHR:                   addr_a = req.instr[6:4];
            OP_MOVRSI:                        addr_a = req.instr[11:9];
            OP_IN, OP_OUT:                    addr_a = req.instr[3:1];
            default:                          addr_a = req.instr[5:3];
        endcase
    end

    // Two copies of the register file give two read ports; both are always written.
    tvm_ram #(.WIDTH(16), .DEPTH(NUM_REGS)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (accept),
        .raddr (addr_a),
        .rdata (rdata_a)
    );

    tvm_ram #(.WIDTH(16), .DEPTH(NUM_REGS)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (accept),
        .raddr (req.instr[2:0]),
        .rdata (rdata_b)
    );

    tvm_ram #(.WIDTH(16), .DEPTH(WORDS)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

    // never-written registers read as zero
    assign opa = rf_valid_reg[addr_a_reg] ? rdata_a : 16'd0;
    assign opb = rf_valid_reg[cur_reg.instr[2:0]] ? rdata_b : 16'd0;

    tvm_exec u_exec (
        .cur    (cur_reg),
        .addr_a (addr_a_reg),
        .opa    (opa),
        .opb    (opb),
        .ex     (ex)
    );

    tvm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (opa),
        .divisor  (opb),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        finish     = 1'b0;
        out_load   = 1'b0;
        rf_we      = 1'b0;
        rf_waddr   = cur_reg.instr[5:3];
        rf_wdata   = mem_rdata;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = ex.mem_addr[MEM_AW:1];
        mem_wdata  = ex.mem_wdata;
        div_start  = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = 16'd0;
                if (clr_cnt_reg == CLR_LAST) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept) state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                res_next.status    = ex.status;
                res_next.new_ip    = ex.new_ip;
                res_next.out_valid = ex.out_valid;
                res_next.out_byte  = ex.out_byte;
                rf_we     = ex.rf_we;
                rf_waddr  = ex.rf_waddr;
                rf_wdata  = ex.rf_wdata;
                mem_we    = ex.mem_we;
                mem_re    = ex.mem_re;
                div_start = ex.div_start;
                if (ex.mem_re) state_next = ST_MEM;
                else if (ex.div_start) state_next = ST_DIV;
                else finish = 1'b1;
            end
            ST_MEM:
            begin
                case (cur_reg.op)
                    OP_MOVRRP:
                    begin
                        rf_we  = 1'b1;
                        finish = 1'b1;
                    end
                    OP_POP:
                    begin
                        rf_we      = 1'b1;
                        rf_waddr   = SP_INDEX;
                        rf_wdata   = a_reg + 16'd2;
                        state_next = ST_WB2;
                    end
                    OP_RET:
                    begin
                        if (mem_rdata[0]) res_next.status = STAT_UMEM;
                        else if ({1'b0, mem_rdata} >= MEM_BYTES_W) res_next.status = STAT_OVF;
                        else
                        begin
                            rf_we           = 1'b1;
                            rf_waddr        = SP_INDEX;
                            rf_wdata        = a_reg + 16'd2;
                            res_next.new_ip = mem_rdata;
                        end
                        finish = 1'b1;
                    end
                    default: finish = 1'b1;
                endcase
            end
            ST_WB2:
            begin
                // pop target written last so pop into SP keeps the loaded value
                rf_we    = 1'b1;
                rf_waddr = cur_reg.instr[2:0];
                finish   = 1'b1;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    rf_we    = 1'b1;
                    rf_wdata = quotient;
                    finish   = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_full_reg || rsp_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (finish)
        begin
            if (!out_full_reg || rsp_ready)
            begin
                out_load   = 1'b1;
                state_next = ST_IDLE;
            end
            else
            begin
                state_next = ST_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            rf_valid_reg <= '0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_cnt_reg <= clr_cnt_reg + MEM_AW'(1);
            if (rf_we) rf_valid_reg[rf_waddr] <= 1'b1;
            if (out_load) out_full_reg <= 1'b1;
            else if (rsp_ready) out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg    <= req;
            addr_a_reg <= addr_a;
        end
        if (state_reg == ST_EXEC) a_reg <= opa;
        res_reg <= res_next;
        if (out_load) out_reg <= res_next;
    end

    assign rsp_valid = out_full_reg;
    assign rsp       = out_reg;

    `TVM_ASSERT_NEXT(a_accept_exec, accept, state_reg == ST_EXEC, "accept not followed by execute")
    `TVM_ASSERT_NOW(a_no_mem_we_div, state_reg == ST_DIV, !mem_we, "memory write while dividing")
    `TVM_ASSERT_NOW(a_out_byte_cont, rsp_valid && rsp.out_valid, rsp.status == STAT_CONT, "byte with failing status")

endmodule

### rtl/tvm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module tvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/tvm_div.sv
// Restoring 16-bit unsigned divider, one quotient bit per cycle.
// Depends on tvm_pkg (imported for house consistency of types).
`timescale 1ns / 1ps

module tvm_div import tvm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] q_reg, q_next;
    logic [15:0] d_reg, d_next;
    logic [16:0] rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        rem_sh    = {rem_reg[15:0], q_reg[15]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 4'd0;
            rem_next  = 17'd0;
            q_next    = dividend;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, d_reg})
            begin
                rem_next = rem_sh - {1'b0, d_reg};
                q_next   = {q_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### rtl/tvm_exec.sv
// Execute stage: decodes the operation and decides status, next IP and writes.
// Depends on tvm_pkg.
`timescale 1ns / 1ps

module tvm_exec import tvm_pkg::*; (
    input  in_t               cur,
    input  logic [REG_AW-1:0] addr_a,
    input  logic [15:0]       opa,
    input  logic [15:0]       opb,
    output exec_t             ex
);

    logic [REG_AW-1:0] ra, rb;
    logic [17:0]       tgt;
    logic [2:0]        tgt_st;
    logic [16:0]       sum;
    logic [31:0]       prod;
    logic [15:0]       sp_dec;
    logic              take;

    always_comb
    begin
        ra     = cur.instr[5:3];
        rb     = cur.instr[2:0];
        // target is relative to the current instruction
        tgt    = {2'b00, cur.next_ip} - 18'd2 + {{10{cur.instr[7]}}, cur.instr[7:0]};
        if (tgt[17] || (tgt[16:0] >= MEM_BYTES_W))
        begin
            tgt_st = STAT_OVF;
        end
        else if (tgt[0])
        begin
            tgt_st = STAT_UMEM;
        end
        else
        begin
            tgt_st = STAT_CONT;
        end
        sum    = {1'b0, opa} + {1'b0, opb};
        prod   = opa * opb;
        sp_dec = opa - 16'd2;
        take   = 1'b0;

        ex           = '0;
        ex.status    = STAT_CONT;
        ex.new_ip    = cur.next_ip;
        ex.rf_waddr  = ra;

        unique case (cur.op)
            OP_MOVRR:
            begin
                ex.rf_we    = 1'b1;
                ex.rf_wdata = opb;
            end
            OP_MOVRRP:
            begin
                if (opb[0]) ex.status = STAT_UMEM;
                else
                begin
                    ex.mem_re   = 1'b1;
                    ex.mem_addr = opb;
                end
            end
            OP_MOVRPR:
            begin
                if (opa[0]) ex.status = STAT_UMEM;
                else
                begin
                    ex.mem_we    = 1'b1;
                    ex.mem_addr  = opa;
                    ex.mem_wdata = opb;
                end
            end
            OP_MOVRSI:
            begin
                ex.rf_we    = 1'b1;
                ex.rf_waddr = addr_a;
                ex.rf_wdata = cur.instr[8] ? {cur.instr[7:0], opa[7:0]}
                                           : {opa[15:8], cur.instr[7:0]};
            end
            OP_PUSH:
            begin
                if (opa[0]) ex.status = STAT_USTK;
                else if (opa < 16'd2) ex.status = STAT_OVF;
                else
                begin
                    ex.rf_we     = 1'b1;
                    ex.rf_waddr  = SP_INDEX;
                    ex.rf_wdata  = sp_dec;
                    ex.mem_we    = 1'b1;
                    ex.mem_addr  = sp_dec;
                    // pushing SP itself stores the decremented value
                    ex.mem_wdata = (rb == SP_INDEX) ? sp_dec : opb;
                end
            end
            OP_POP:
            begin
                if (opa[0]) ex.status = STAT_USTK;
                else if (opa > POP_SP_MAX) ex.status = STAT_OVF;
                else
                begin
                    ex.mem_re   = 1'b1;
                    ex.mem_addr = opa;
                end
            end
            OP_CALL:
            begin
                if (opa < 16'd2) ex.status = STAT_OVF;
                else if (opa[0]) ex.status = STAT_USTK;
                else if (tgt_st != STAT_CONT) ex.status = tgt_st;
                else
                begin
                    ex.rf_we     = 1'b1;
                    ex.rf_waddr  = SP_INDEX;
                    ex.rf_wdata  = sp_dec;
                    ex.mem_we    = 1'b1;
                    ex.mem_addr  = sp_dec;
                    ex.mem_wdata = cur.next_ip;
                    ex.new_ip    = tgt[15:0];
                end
            end
            OP_RET:
            begin
                if (opa[0]) ex.status = STAT_USTK;
                else if (opa == RET_SP_BAD) ex.status = STAT_OVF;
                else
                begin
                    ex.mem_re   = 1'b1;
                    ex.mem_addr = opa;
                end
            end
            OP_ADD:
            begin
                if (sum[16]) ex.status = STAT_OVF;
                else
                begin
                    ex.rf_we    = 1'b1;
                    ex.rf_wdata = sum[15:0];
                end
            end
            OP_SUB:
            begin
                if (opa < opb) ex.status = STAT_OVF;
                else
                begin
                    ex.rf_we    = 1'b1;
                    ex.rf_wdata = opa - opb;
                end
            end
            OP_MUL:
            begin
                if (|prod[31:16]) ex.status = STAT_OVF;
                else
                begin
                    ex.rf_we    = 1'b1;
                    ex.rf_wdata = prod[15:0];
                end
            end
            OP_DIV:
            begin
                if (opb == 16'd0) ex.status = STAT_DBZ;
                else ex.div_start = 1'b1;
            end
            OP_AND:
            begin
                ex.rf_we    = 1'b1;
                ex.rf_wdata = opa & opb;
            end
            OP_OR:
            begin
                ex.rf_we    = 1'b1;
                ex.rf_wdata = opa | opb;
            end
            OP_XOR:
            begin
                ex.rf_we    = 1'b1;
                ex.rf_wdata = opa ^ opb;
            end
            OP_NOT:
            begin
                ex.rf_we    = 1'b1;
                ex.rf_waddr = rb;
                ex.rf_wdata = ~opb;
            end
            OP_SHL:
            begin
                ex.rf_we    = 1'b1;
                ex.rf_waddr = addr_a;
                ex.rf_wdata = opa << cur.instr[3:0];
            end
            OP_SHR:
            begin
                ex.rf_we    = 1'b1;
                ex.rf_waddr = addr_a;
                ex.rf_wdata = opa >> cur.instr[3:0];
            end
            OP_HALT:
            begin
                ex.status = STAT_HALT;
            end
            OP_JMP, OP_JE, OP_JNE:
            begin
                take = (cur.op == OP_JMP) || ((cur.op == OP_JE) && (opa == 16'd0))
                    || ((cur.op == OP_JNE) && (opa != 16'd0));
                if (take)
                begin
                    ex.status = tgt_st;
                    if (tgt_st == STAT_CONT) ex.new_ip = tgt[15:0];
                end
            end
            OP_IN:
            begin
                ex.rf_we    = 1'b1;
                ex.rf_waddr = addr_a;
                ex.rf_wdata = cur.instr[0] ? {cur.in_byte, opa[7:0]}
                                           : {opa[15:8], cur.in_byte};
            end
            OP_OUT:
            begin
                if (cur.output_refused) ex.status = STAT_IO;
                else
                begin
                    ex.out_valid = 1'b1;
                    ex.out_byte  = cur.instr[0] ? opa[15:8] : opa[7:0];
                end
            end
            default:
            begin
                // nop and unused codes
            end
        endcase
    end

endmodule

### tb/tb_toy_vm_execute_unit.sv
// Self-checking testbench for toy_vm_execute_unit: directed table, then random programmes.
// Depends on tvm_pkg and the RTL of the execute unit; a local model predicts every result that the table does not fix.
`timescale 1ns / 1ps

module tb_toy_vm_execute_unit;
    import tvm_pkg::*;

    localparam int N_RANDOM     = 1600;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [4:0] OP_SPARE_LO = 5'd25;
    localparam logic [4:0] OP_SPARE_HI = 5'd31;
    localparam logic [3:0] SEL_SP_LO   = 4'd14;
    localparam logic [3:0] SEL_SP_HI   = 4'd15;

    typedef struct {
        in_t  item;
        logic fixed;
        out_t want;
    } vec_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_ready = 1'b0;
    in_t  req       = '0;
    logic req_ready;
    logic rsp_valid;
    out_t rsp;

    // Typed expectation travelling with the current transaction, if any.
    logic fix_en  = 1'b0;
    out_t fix_val = '0;

    logic [15:0] regs [NUM_REGS];
    logic [15:0] mem  [WORDS];
    out_t        pending [$];

    int tx_idle  = 0;
    int rx_idle  = 0;
    int cycles   = 0;
    int accepted = 0;
    int checked  = 0;
    int errors   = 0;
    int by_status [8];
    vec_t dir_tab [$];

    toy_vm_execute_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [2:0] jump_target(input in_t x, output logic [15:0] tgt);
        int t;
        t = int'(x.next_ip) - 2 + int'($signed(x.instr[7:0]));
        tgt = 16'(t);
        if (t < 0 || t >= MEM_BYTES)
            return STAT_OVF;
        if (t[0])
            return STAT_UMEM;
        return STAT_CONT;
    endfunction

    // Executes one instruction on the local machine state.
    task automatic exec_instr(input in_t x, output out_t r);
        logic [2:0]  ra, rb, st;
        logic [15:0] sp, ip, v, tgt;
        logic [3:0]  k;
        logic [16:0] sum;
        logic [31:0] prod;
        ra = x.instr[5:3];
        rb = x.instr[2:0];
        sp = regs[SP_INDEX];
        st = STAT_CONT;
        ip = x.next_ip;
        r  = '0;
        case (x.op)
            OP_MOVRR: regs[ra] = regs[rb];
            OP_MOVRRP:
                if (regs[rb][0]) st = STAT_UMEM;
                else regs[ra] = mem[regs[rb][15:1]];
            OP_MOVRPR:
                if (regs[ra][0]) st = STAT_UMEM;
                else mem[regs[ra][15:1]] = regs[rb];
            OP_MOVRSI:
            begin
                k = x.instr[11:8];
                if (k[0]) regs[k[3:1]][15:8] = x.instr[7:0];
                else regs[k[3:1]][7:0] = x.instr[7:0];
            end
            OP_PUSH:
                if (sp[0]) st = STAT_USTK;
                else if (sp < 16'd2) st = STAT_OVF;
                else
                begin
                    regs[SP_INDEX] = sp - 16'd2;
                    mem[regs[SP_INDEX][15:1]] = regs[rb];
                end
            OP_POP:
                if (sp[0]) st = STAT_USTK;
                else if (sp > POP_SP_MAX) st = STAT_OVF;
                else
                begin
                    v = mem[sp[15:1]];
                    regs[SP_INDEX] = sp + 16'd2;
                    regs[rb] = v;
                end
            OP_CALL:
                if (sp < 16'd2) st = STAT_OVF;
                else if (sp[0]) st = STAT_USTK;
                else
                begin
                    st = jump_target(x, tgt);
                    if (st == STAT_CONT)
                    begin
                        regs[SP_INDEX] = sp - 16'd2;
                        mem[regs[SP_INDEX][15:1]] = x.next_ip;
                        ip = tgt;
                    end
                end
            OP_RET:
                if (sp[0]) st = STAT_USTK;
                else if (sp == RET_SP_BAD) st = STAT_OVF;
                else
                begin
                    v = mem[sp[15:1]];
                    if (v[0]) st = STAT_UMEM;
                    else
                    begin
                        regs[SP_INDEX] = sp + 16'd2;
                        ip = v;
                    end
                end
            OP_ADD:
            begin
                sum = {1'b0, regs[ra]} + {1'b0, regs[rb]};
                if (sum[16]) st = STAT_OVF;
                else regs[ra] = sum[15:0];
            end
            OP_SUB:
                if (regs[ra] < regs[rb]) st = STAT_OVF;
                else regs[ra] = regs[ra] - regs[rb];
            OP_MUL:
            begin
                prod = 32'(regs[ra]) * 32'(regs[rb]);
                if (prod > 32'hFFFF) st = STAT_OVF;
                else regs[ra] = prod[15:0];
            end
            OP_DIV:
                if (regs[rb] == 16'd0) st = STAT_DBZ;
                else regs[ra] = regs[ra] / regs[rb];
            OP_AND:  regs[ra] = regs[ra] & regs[rb];
            OP_OR:   regs[ra] = regs[ra] | regs[rb];
            OP_XOR:  regs[ra] = regs[ra] ^ regs[rb];
            OP_NOT:  regs[rb] = ~regs[rb];
            OP_SHL:  regs[x.instr[6:4]] = regs[x.instr[6:4]] << x.instr[3:0];
            OP_SHR:  regs[x.instr[6:4]] = regs[x.instr[6:4]] >> x.instr[3:0];
            OP_HALT: st = STAT_HALT;
            OP_JMP, OP_JE, OP_JNE:
            begin
                v = regs[x.instr[10:8]];
                if (!((x.op == OP_JE && v != 16'd0) || (x.op == OP_JNE && v == 16'd0)))
                begin
                    st = jump_target(x, tgt);
                    if (st == STAT_CONT) ip = tgt;
                end
            end
            OP_IN:
            begin
                k = x.instr[3:0];
                if (k[0]) regs[k[3:1]][15:8] = x.in_byte;
                else regs[k[3:1]][7:0] = x.in_byte;
            end
            OP_OUT:
            begin
                k = x.instr[3:0];
                if (x.output_refused) st = STAT_IO;
                else
                begin
                    r.out_valid = 1'b1;
                    r.out_byte  = k[0] ? regs[k[3:1]][15:8] : regs[k[3:1]][7:0];
                end
            end
            default: ;
        endcase
        r.status = st;
        r.new_ip = (st == STAT_CONT) ? ip : x.next_ip;
    endtask

    always @(posedge clk)
    begin : scoreboard
        out_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result st=%0d ip=%h ov=%b ob=%h",
                             rsp.status, rsp.new_ip, rsp.out_valid, rsp.out_byte);
            end
            else
            begin
                want = pending.pop_front();
                checked++;
                by_status[rsp.status]++;
                if (rsp.status !== want.status || rsp.new_ip !== want.new_ip ||
                    rsp.out_valid !== want.out_valid || rsp.out_byte !== want.out_byte)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch #%0d: exp st=%0d ip=%h ov=%b ob=%h",
                                 checked, want.status, want.new_ip, want.out_valid,
                                 want.out_byte);
                        $display("    got st=%0d ip=%h ov=%b ob=%h",
                                 rsp.status, rsp.new_ip, rsp.out_valid, rsp.out_byte);
                    end
                end
            end
        end
        // Response first: a transaction accepted on this edge cannot answer on it.
        if (rst_n && req_valid && req_ready)
        begin
            exec_instr(req, want);
            if (fix_en)
                want = fix_val;
            pending.push_back(want);
            accepted++;
        end
    end

    always @(posedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= rx_idle);

    task automatic send(input in_t x, input logic fx, input out_t fe);
        if ($urandom_range(0, 99) < tx_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle)
                @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= x;
        fix_en    <= fx;
        fix_val   <= fe;
        forever
        begin
            @(negedge clk);
            if (req_ready)
                break;
        end
        @(posedge clk);
    endtask

    function automatic in_t mk(input logic [4:0] op, input logic [15:0] instr,
                               input logic [15:0] nip, input logic [7:0] ib, input logic refuse);
        in_t x;
        x.op = op;
        x.instr = instr;
        x.next_ip = nip;
        x.in_byte = ib;
        x.output_refused = refuse;
        return x;
    endfunction

    function automatic in_t rand_item(input logic [4:0] op);
        logic [15:0] nip;
        nip = 16'($urandom);
        if ($urandom_range(0, 3) != 0)
            nip[0] = 1'b0;
        return mk(op, 16'($urandom), nip, 8'($urandom), ($urandom_range(0, 3) == 0));
    endfunction

    function automatic logic [4:0] rand_op();
        if ($urandom_range(0, 15) == 0)
            return 5'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        return 5'($urandom_range(OP_MOVRR, OP_OUT));
    endfunction

    task automatic add_row(input in_t x, input logic fx, input logic [2:0] st,
                           input logic [15:0] ip, input logic ov, input logic [7:0] ob);
        vec_t v;
        v.item = x;
        v.fixed = fx;
        v.want = '{status: st, new_ip: ip, out_valid: ov, out_byte: ob};
        dir_tab.push_back(v);
    endtask

    // Sender goes quiet until every outstanding result is back.
    task automatic drain();
        req_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    // Stack frame: point SP somewhere even, nest calls and pushes, unwind them.
    task automatic stack_frame();
        int depth;
        in_t x;
        send(mk(OP_MOVRSI, {4'd0, SEL_SP_LO, 8'($urandom) & 8'hFE}, 16'h0100, 8'h00, 1'b0),
             1'b0, '0);
        send(mk(OP_MOVRSI, {4'd0, SEL_SP_HI, 8'($urandom)}, 16'h0102, 8'h00, 1'b0), 1'b0, '0);
        depth = $urandom_range(1, 4);
        for (int i = 0; i < depth; i++)
        begin
            x = rand_item($urandom_range(0, 1) ? OP_CALL : OP_PUSH);
            send(x, 1'b0, '0);
            if ($urandom_range(0, 1))
                send(rand_item(5'($urandom_range(OP_MOVRR, OP_SHR))), 1'b0, '0);
        end
        for (int i = 0; i < depth; i++)
            send(rand_item($urandom_range(0, 1) ? OP_RET : OP_POP), 1'b0, '0);
    endtask

    initial
    begin
        int n;
        foreach (regs[i])
            regs[i] = '0;
        foreach (mem[i])
            mem[i] = '0;
        foreach (by_status[i])
            by_status[i] = 0;

        // Rows run from reset state; SP starts at zero.
        add_row(mk(OP_HALT,   16'h0000, 16'h0100, 8'h00, 1'b0), 1, STAT_HALT, 16'h0100, 0, 0);
        add_row(mk(OP_PUSH,   16'h0000, 16'h0100, 8'h00, 1'b0), 1, STAT_OVF,  16'h0100, 0, 0);
        add_row(mk(OP_DIV,    16'h0001, 16'h0100, 8'h00, 1'b0), 1, STAT_DBZ,  16'h0100, 0, 0);
        add_row(mk(OP_OUT,    16'h0000, 16'h0100, 8'h00, 1'b1), 1, STAT_IO,   16'h0100, 0, 0);
        add_row(mk(OP_JMP,    16'h0080, 16'h0002, 8'h00, 1'b0), 1, STAT_OVF,  16'h0002, 0, 0);
        add_row(mk(OP_JMP,    16'h0001, 16'h0002, 8'h00, 1'b0), 1, STAT_UMEM, 16'h0002, 0, 0);
        add_row(mk(OP_POP,    16'h0000, 16'h0100, 8'h00, 1'b0), 0, 0, 0, 0, 0);
        add_row(mk(OP_MOVRSI, 16'h0EFF, 16'h0100, 8'h00, 1'b0), 0, 0, 0, 0, 0);
        add_row(mk(OP_PUSH,   16'h0000, 16'h0100, 8'h00, 1'b0), 1, STAT_USTK, 16'h0100, 0, 0);
        add_row(mk(OP_CALL,   16'h0004, 16'h0100, 8'h00, 1'b0), 1, STAT_USTK, 16'h0100, 0, 0);
        add_row(mk(OP_RET,    16'h0000, 16'h0100, 8'h00, 1'b0), 1, STAT_USTK, 16'h0100, 0, 0);
        add_row(mk(OP_MOVRSI, 16'h0FFF, 16'h0100, 8'h00, 1'b0), 0, 0, 0, 0, 0);
        add_row(mk(OP_MOVRSI, 16'h0EFE, 16'h0100, 8'h00, 1'b0), 0, 0, 0, 0, 0);
        add_row(mk(OP_RET,    16'h0000, 16'h0100, 8'h00, 1'b0), 1, STAT_OVF,  16'h0100, 0, 0);
        add_row(mk(OP_POP,    16'h0000, 16'h0100, 8'h00, 1'b0), 1, STAT_OVF,  16'h0100, 0, 0);
        add_row(mk(OP_CALL,   16'h0004, 16'hFFFE, 8'h00, 1'b0), 0, 0, 0, 0, 0);
        add_row(mk(OP_RET,    16'h0000, 16'h0100, 8'h00, 1'b0), 0, 0, 0, 0, 0);
        add_row(mk(OP_IN,     16'h0003, 16'h0100, 8'hFF, 1'b0), 0, 0, 0, 0, 0);
        add_row(mk(OP_IN,     16'h0002, 16'h0100, 8'hFF, 1'b0), 0, 0, 0, 0, 0);
        add_row(mk(OP_ADD,    16'h0009, 16'h0100, 8'h00, 1'b0), 0, 0, 0, 0, 0);
        add_row(mk(OP_MUL,    16'h0009, 16'h0100, 8'h00, 1'b0), 0, 0, 0, 0, 0);
        add_row(mk(OP_SUB,    16'h0001, 16'h0100, 8'h00, 1'b0), 0, 0, 0, 0, 0);
        add_row(mk(OP_SHL,    16'h001F, 16'h0100, 8'h00, 1'b0), 0, 0, 0, 0, 0);
        add_row(mk(OP_SHR,    16'h001F, 16'h0100, 8'h00, 1'b0), 0, 0, 0, 0, 0);
        add_row(mk(OP_NOT,    16'h0001, 16'h0100, 8'h00, 1'b0), 0, 0, 0, 0, 0);
        add_row(mk(OP_OUT,    16'h0003, 16'h0100, 8'h00, 1'b0), 0, 0, 0, 0, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            send(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].want);
        // The rest of the operations, once each, against the model.
        foreach (dir_tab[i])
            if (i < 1)
            begin
                send(mk(OP_MOVRR,  16'h0039, 16'h0100, 8'h00, 1'b0), 1'b0, '0);
                send(mk(OP_MOVRPR, 16'h0001, 16'h0100, 8'h00, 1'b0), 1'b0, '0);
                send(mk(OP_MOVRRP, 16'h0008, 16'h0100, 8'h00, 1'b0), 1'b0, '0);
                send(mk(OP_AND,    16'h0011, 16'h0100, 8'h00, 1'b0), 1'b0, '0);
                send(mk(OP_OR,     16'h0011, 16'h0100, 8'h00, 1'b0), 1'b0, '0);
                send(mk(OP_XOR,    16'h0011, 16'h0100, 8'h00, 1'b0), 1'b0, '0);
                send(mk(OP_JE,     16'h0010, 16'h0100, 8'h00, 1'b0), 1'b0, '0);
                send(mk(OP_JNE,    16'h01F0, 16'h0100, 8'h00, 1'b0), 1'b0, '0);
                send(mk(OP_NOP,    16'hFFFF, 16'h0100, 8'h00, 1'b0), 1'b0, '0);
                send(mk(OP_SPARE_HI, 16'hFFFF, 16'h0100, 8'h00, 1'b0), 1'b0, '0);
            end

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle = (phase == 0) ? 36 : (phase == 1) ? 50 : 0;
            rx_idle = (phase == 0) ? 50 : (phase == 1) ? 36 : 0;
            n = accepted + N_RANDOM / 3;
            while (accepted < n)
            begin
                if ($urandom_range(0, 9) < 3)
                    stack_frame();
                else
                    send(rand_item(rand_op()), 1'b0, '0);
            end
            // Hold the sender off until every result is home.
            drain();
        end
        req_valid <= 1'b0;
        fix_en    <= 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d instructions executed, %0d results checked in %0d cycles",
                 accepted, checked, cycles);
        $display("status mix: cont %0d halt %0d ovf %0d umem %0d ustk %0d dbz %0d io %0d",
                 by_status[STAT_CONT], by_status[STAT_HALT], by_status[STAT_OVF],
                 by_status[STAT_UMEM], by_status[STAT_USTK], by_status[STAT_DBZ],
                 by_status[STAT_IO]);
        if (errors == 0 && pending.size() == 0)
            $display("[ OK ] regression clean");
        else
        begin
            $display("%0d failures, %0d results outstanding", errors, pending.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
